>>> rtl/page_free_list_allocator_defines.svh
// ----------------------------------------------------------------------------
// Page free list allocator assertion macros
// Shared property forms for the allocator blocks; expect i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define PFLA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PFLA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// Page free list allocator package
// Shared types, command and status codes, and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfla_pkg;

    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int ALU_W     = ADDR_W + 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP    = 2'd2;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST  = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] KERNEL_BASE_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST    = 32'h0E00_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_ADDR,
        S_RND,
        S_END_ADD,
        S_END_CMP,
        S_KEND,
        S_PHYS,
        S_TOP,
        S_PUSH,
        S_RESP
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] kernel_end;
        logic [ADDR_W-1:0] kernel_base;
        logic [ADDR_W-1:0] phys_top;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] range_end;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] page_addr;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  pages_freed;
    } t_result;

endpackage

>>> rtl/pfla_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocator command transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfla_req_if;
    logic                       valid;
    logic                       ready;
    logic [pfla_pkg::CMD_W-1:0]  cmd;
    logic [pfla_pkg::ADDR_W-1:0] addr;
    logic [pfla_pkg::ADDR_W-1:0] range_end;

    modport source (output valid, output cmd, output addr, output range_end, input ready);
    modport sink   (input valid, input cmd, input addr, input range_end, output ready);
endinterface

>>> rtl/pfla_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one allocator result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfla_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pfla_pkg::ADDR_W-1:0] page_addr;
    logic [pfla_pkg::ST_W-1:0]   status;
    logic [pfla_pkg::CNT_W-1:0]  pages_freed;

    modport source (output valid, output page_addr, output status, output pages_freed,
                    input ready);
    modport sink   (input valid, input page_addr, input status, input pages_freed,
                    output ready);
endinterface

>>> rtl/pfla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfla_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pfla_alu.sv
// ----------------------------------------------------------------------------
// Allocator shared arithmetic unit
// One 33-bit adder/subtractor for all address sums and all bounds but page count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfla_alu (
    input  pfla_pkg::t_alu_req i_req,
    output pfla_pkg::t_alu_rsp o_rsp
);

    logic [pfla_pkg::ALU_W:0] diff;

    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        o_rsp = '0;
        unique case (i_req.op)
            pfla_pkg::ALU_ADD: begin
                o_rsp.res    = i_req.a + i_req.b;
                o_rsp.borrow = 1'b0;
            end
            pfla_pkg::ALU_SUB: begin
                o_rsp.res    = diff[pfla_pkg::ALU_W-1:0];
                o_rsp.borrow = diff[pfla_pkg::ALU_W];
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

>>> rtl/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Steps each command through the shared adder and the next-link memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_free_list_allocator_defines.svh"

module pfla_ctrl #(
    parameter int PAGE_COUNT = 65536,
    parameter int PAGE_SIZE  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pfla_pkg::t_req    i_req,
    input  pfla_pkg::t_cfg    i_cfg,
    output logic              o_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output pfla_pkg::t_result o_res
);

    localparam int IW = $clog2(PAGE_COUNT);
    localparam int SH = $clog2(PAGE_SIZE);
    localparam int AW = pfla_pkg::ADDR_W;
    localparam int XW = pfla_pkg::ALU_W;
    localparam logic [XW-1:0] PS_EXT  = XW'(PAGE_SIZE);
    localparam logic [XW-1:0] PS_MASK = XW'(PAGE_SIZE - 1);
    localparam logic [AW-1:0] PC_EXT  = AW'(PAGE_COUNT);
    localparam logic [IW:0]   EMPTY   = {1'b1, {IW{1'b0}}};

    pfla_pkg::t_state r_state, n_state;
    logic [pfla_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [AW-1:0]              r_p, n_p;
    logic [XW-1:0]              r_pn, n_pn;
    logic [AW-1:0]              r_rend, n_rend;
    logic [AW-1:0]              r_phys, n_phys;
    logic [IW:0]                r_head, n_head;
    logic [pfla_pkg::ST_W-1:0]  r_status, n_status;
    logic [pfla_pkg::CNT_W-1:0] r_freed, n_freed;
    logic [AW-1:0]              r_page_addr, n_page_addr;

    pfla_pkg::t_alu_req alu_req;
    pfla_pkg::t_alu_rsp alu_rsp;

    logic          ram_we;
    logic          ram_re;
    logic [IW-1:0] ram_waddr;
    logic [IW:0]   ram_rdata;
    logic [AW-1:0] phys_page;
    logic [XW-1:0] rounded;

    pfla_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    pfla_ram #(
        .WIDTH (IW + 1),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_head),
        .i_re    (ram_re),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign phys_page = r_phys >> SH;
    assign ram_waddr = phys_page[IW-1:0];
    assign rounded   = alu_rsp.res & ~PS_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfla_pkg::S_IDLE;
            r_head  <= EMPTY;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_p         <= n_p;
        r_pn        <= n_pn;
        r_rend      <= n_rend;
        r_phys      <= n_phys;
        r_status    <= n_status;
        r_freed     <= n_freed;
        r_page_addr <= n_page_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_p         = r_p;
        n_pn        = r_pn;
        n_rend      = r_rend;
        n_phys      = r_phys;
        n_head      = r_head;
        n_status    = r_status;
        n_freed     = r_freed;
        n_page_addr = r_page_addr;
        alu_req.op  = pfla_pkg::ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            pfla_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd       = i_req.cmd;
                    n_p         = i_req.addr;
                    n_rend      = i_req.range_end;
                    n_status    = pfla_pkg::ST_OK;
                    n_freed     = '0;
                    n_page_addr = '0;
                    unique case (i_req.cmd)
                        pfla_pkg::CMD_ALLOC: n_state = pfla_pkg::S_ALLOC_RD;
                        pfla_pkg::CMD_FREE:  n_state = pfla_pkg::S_KEND;
                        pfla_pkg::CMD_RANGE: n_state = pfla_pkg::S_RND;
                        default:             n_state = pfla_pkg::S_RESP;
                    endcase
                end
            end
            pfla_pkg::S_ALLOC_RD: begin
                if (r_head[IW]) begin
                    n_status = pfla_pkg::ST_EMPTY;
                    n_state  = pfla_pkg::S_RESP;
                end else begin
                    ram_re  = 1'b1;
                    n_state = pfla_pkg::S_ALLOC_ADDR;
                end
            end
            pfla_pkg::S_ALLOC_ADDR: begin
                alu_req.op  = pfla_pkg::ALU_ADD;
                alu_req.a   = XW'(AW'(r_head[IW-1:0]) << SH);
                alu_req.b   = {1'b0, i_cfg.kernel_base};
                n_page_addr = alu_rsp.res[AW-1:0];
                n_head      = ram_rdata;
                n_state     = pfla_pkg::S_RESP;
            end
            pfla_pkg::S_RND: begin
                alu_req.op = pfla_pkg::ALU_ADD;
                alu_req.a  = {1'b0, r_p};
                alu_req.b  = PS_MASK;
                if (rounded[AW]) begin
                    n_state = pfla_pkg::S_RESP;
                end else begin
                    n_p     = rounded[AW-1:0];
                    n_state = pfla_pkg::S_END_ADD;
                end
            end
            pfla_pkg::S_END_ADD: begin
                alu_req.op = pfla_pkg::ALU_ADD;
                alu_req.a  = {1'b0, r_p};
                alu_req.b  = PS_EXT;
                n_pn       = alu_rsp.res;
                n_state    = pfla_pkg::S_END_CMP;
            end
            pfla_pkg::S_END_CMP: begin
                alu_req.op = pfla_pkg::ALU_SUB;
                alu_req.a  = {1'b0, r_rend};
                alu_req.b  = r_pn;
                n_state    = alu_rsp.borrow ? pfla_pkg::S_RESP : pfla_pkg::S_KEND;
            end
            pfla_pkg::S_KEND: begin
                alu_req.op = pfla_pkg::ALU_SUB;
                alu_req.a  = {1'b0, r_p};
                alu_req.b  = {1'b0, i_cfg.kernel_end};
                if (alu_rsp.borrow || (r_p[SH-1:0] != '0)) begin
                    n_status = pfla_pkg::ST_INVALID;
                    n_state  = pfla_pkg::S_RESP;
                end else begin
                    n_state = pfla_pkg::S_PHYS;
                end
            end
            pfla_pkg::S_PHYS: begin
                alu_req.op = pfla_pkg::ALU_SUB;
                alu_req.a  = {1'b0, r_p};
                alu_req.b  = {1'b0, i_cfg.kernel_base};
                n_phys     = alu_rsp.res[AW-1:0];
                n_state    = pfla_pkg::S_TOP;
            end
            pfla_pkg::S_TOP: begin
                alu_req.op = pfla_pkg::ALU_SUB;
                alu_req.a  = {1'b0, r_phys};
                alu_req.b  = {1'b0, i_cfg.phys_top};
                if (!alu_rsp.borrow || (phys_page >= PC_EXT)) begin
                    n_status = pfla_pkg::ST_INVALID;
                    n_state  = pfla_pkg::S_RESP;
                end else begin
                    n_state = pfla_pkg::S_PUSH;
                end
            end
            pfla_pkg::S_PUSH: begin
                ram_we  = 1'b1;
                n_head  = {1'b0, ram_waddr};
                n_freed = r_freed + 1'b1;
                if (r_cmd == pfla_pkg::CMD_RANGE) begin
                    n_p     = r_pn[AW-1:0];
                    n_state = pfla_pkg::S_END_ADD;
                end else begin
                    n_state = pfla_pkg::S_RESP;
                end
            end
            pfla_pkg::S_RESP: begin
                if (i_res_ready) begin
                    n_state = pfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready           = (r_state == pfla_pkg::S_IDLE);
    assign o_res_valid       = (r_state == pfla_pkg::S_RESP);
    assign o_res.page_addr   = r_page_addr;
    assign o_res.status      = r_status;
    assign o_res.pages_freed = r_freed;

    `PFLA_ASSERT_IMPLY(a_ram_single_access, ram_we, !ram_re, "link read and write collide")
    `PFLA_ASSERT_IMPLY(a_alloc_order, r_state == pfla_pkg::S_ALLOC_ADDR, $past(r_state) == pfla_pkg::S_ALLOC_RD, "alloc address without link read")
    `PFLA_ASSERT_NEXT(a_push_moves_head, ram_we, r_head == $past({1'b0, ram_waddr}), "head does not follow pushed page")
    `PFLA_ASSERT_NEXT(a_start_leaves_idle, i_start, r_state != pfla_pkg::S_IDLE, "accepted command left sequencer idle")
    `PFLA_ASSERT_IMPLY(a_empty_only_on_marker, (r_state == pfla_pkg::S_RESP) && (r_status == pfla_pkg::ST_EMPTY), r_head[IW], "empty status with pages on list")

endmodule

>>> rtl/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Page free list allocator
// LIFO free list of fixed-size pages with alloc, free and free-range commands.
// ----------------------------------------------------------------------------
// A command is taken only while the sequencer is idle; its result lands in an
// output register, so the next command is taken while that result waits. The
// address sums and bound checks but the page-count limit use one 33-bit adder,
// one step per cycle, and the links sit in a memory with one write port and
// one registered read port. Alloc reads the head link, then forms the page
// address, or reports empty at once; free page checks alignment and kernel
// end, forms the physical address, then checks the top and the page count and
// pushes; free range rounds the start up, then for each page checks the end,
// runs the free-page checks and pushes, stops at a rejected page, and ends at
// once when the start rounds past the top of the address space. The link
// memory needs no clearing after reset; the block is ready at once.
`timescale 1ns / 1ps

module page_free_list_allocator #(
    parameter int PAGE_COUNT = 65536,
    parameter int PAGE_SIZE  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pfla_req_if.sink                       i_req,
    pfla_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pfla_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfla_pkg::ADDR_W-1:0]    i_cfg_wdata
);

    pfla_pkg::t_cfg    r_cfg;
    pfla_pkg::t_req    req;
    pfla_pkg::t_result res;
    pfla_pkg::t_result r_out;
    logic              r_out_valid;
    logic              ready;
    logic              start;
    logic              res_valid;
    logic              res_ready;

    assign req.cmd       = i_req.cmd;
    assign req.addr      = i_req.addr;
    assign req.range_end = i_req.range_end;
    assign start         = i_req.valid && ready;
    assign i_req.ready   = ready;
    assign res_ready     = !r_out_valid || o_rsp.ready;

    pfla_ctrl #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SIZE  (PAGE_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_cfg       (r_cfg),
        .o_ready     (ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_end  <= pfla_pkg::KERNEL_END_RST;
            r_cfg.kernel_base <= pfla_pkg::KERNEL_BASE_RST;
            r_cfg.phys_top    <= pfla_pkg::PHYS_TOP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfla_pkg::CFG_KERNEL_END:  r_cfg.kernel_end  <= i_cfg_wdata;
                pfla_pkg::CFG_KERNEL_BASE: r_cfg.kernel_base <= i_cfg_wdata;
                pfla_pkg::CFG_PHYS_TOP:    r_cfg.phys_top    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.page_addr   = r_out.page_addr;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.pages_freed = r_out.pages_freed;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page free list allocator testbench
// Drives alloc, free, free-range and undefined commands on the request channel
// under several register settings, with random stalls on both channels. A
// shadow of the free list and its links predicts each result not fixed by a
// directed row; each result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module testbench;

    localparam int PAGE_COUNT        = 65536;
    localparam int PAGE_SIZE         = 4096;
    localparam int CLK_PERIOD        = 8;
    localparam int WATCHDOG_LIMIT    = 60000;
    localparam int DRAIN_CYCLES      = 20;
    localparam int ITEMS_PER_SETTING = 130;

    localparam logic [pfla_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [pfla_pkg::CMD_W-1:0]  cmd;
        logic [pfla_pkg::ADDR_W-1:0] addr;
        logic [pfla_pkg::ADDR_W-1:0] range_end;
        bit                          fixed;
        pfla_pkg::t_result           want;
    } t_vector;

    typedef struct {
        logic [pfla_pkg::ADDR_W-1:0] kernel_end;
        logic [pfla_pkg::ADDR_W-1:0] kernel_base;
        logic [pfla_pkg::ADDR_W-1:0] phys_top;
        int                          lo;
        int                          hi;
    } t_setting;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [pfla_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [pfla_pkg::ADDR_W-1:0]    cfg_wdata;

    pfla_req_if req_ch ();
    pfla_rsp_if rsp_ch ();

    logic              row_fixed;
    pfla_pkg::t_result row_want;

    pfla_pkg::t_cfg    shadow_cfg;
    logic [16:0]       head_idx;
    logic [16:0]       link_mem [PAGE_COUNT];
    pfla_pkg::t_result awaited_results [$];

    int n_issued;
    int n_returned;
    int mismatches;
    int idle_cycles;
    int hold_left;
    bit idle_on;

    t_vector  directed_rows [25];
    t_setting settings [6];

    page_free_list_allocator #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SIZE  (PAGE_SIZE)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end
        if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bit push_page(logic [pfla_pkg::ADDR_W-1:0] va);
        logic [pfla_pkg::ADDR_W-1:0] pa;
        pa = va - shadow_cfg.kernel_base;
        if (va % PAGE_SIZE != 0 || va < shadow_cfg.kernel_end || pa >= shadow_cfg.phys_top ||
            pa / PAGE_SIZE >= PAGE_COUNT) begin
            return 1'b0;
        end
        link_mem[pa / PAGE_SIZE] = head_idx;
        head_idx = 17'(pa / PAGE_SIZE);
        return 1'b1;
    endfunction

    function automatic pfla_pkg::t_result apply_command(logic [pfla_pkg::CMD_W-1:0] c,
                                                        logic [pfla_pkg::ADDR_W-1:0] a,
                                                        logic [pfla_pkg::ADDR_W-1:0] e);
        pfla_pkg::t_result res;
        longint unsigned   pos;
        res = '0;
        case (c)
            pfla_pkg::CMD_ALLOC: begin
                if (head_idx >= PAGE_COUNT) begin
                    res.status = pfla_pkg::ST_EMPTY;
                end else begin
                    res.page_addr = 32'(head_idx) * PAGE_SIZE + shadow_cfg.kernel_base;
                    head_idx = link_mem[head_idx];
                end
            end
            pfla_pkg::CMD_FREE: begin
                if (push_page(a)) begin
                    res.pages_freed = 17'd1;
                end else begin
                    res.status = pfla_pkg::ST_INVALID;
                end
            end
            pfla_pkg::CMD_RANGE: begin
                pos = a;
                pos = (pos + PAGE_SIZE - 1) / PAGE_SIZE * PAGE_SIZE;
                while (pos + PAGE_SIZE <= e) begin
                    if (!push_page(pos[31:0])) begin
                        res.status = pfla_pkg::ST_INVALID;
                        break;
                    end
                    res.pages_freed = res.pages_freed + 1'b1;
                    pos = pos + PAGE_SIZE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [pfla_pkg::ADDR_W-1:0] want,
                                        logic [pfla_pkg::ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        pfla_pkg::t_result want;
        bit                busy;
        busy = 1'b0;
        if (!i_rst_n) begin
            head_idx = 17'(PAGE_COUNT);
            shadow_cfg = '{pfla_pkg::KERNEL_END_RST, pfla_pkg::KERNEL_BASE_RST,
                           pfla_pkg::PHYS_TOP_RST};
        end else begin
            if (cfg_we) begin
                busy = 1'b1;
                case (cfg_idx)
                    pfla_pkg::CFG_KERNEL_END:  shadow_cfg.kernel_end = cfg_wdata;
                    pfla_pkg::CFG_KERNEL_BASE: shadow_cfg.kernel_base = cfg_wdata;
                    pfla_pkg::CFG_PHYS_TOP:    shadow_cfg.phys_top = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                busy = 1'b1;
                n_returned++;
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing expected: page_addr %0h",
                           rsp_ch.page_addr);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("page_addr", want.page_addr, rsp_ch.page_addr);
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("pages_freed", 32'(want.pages_freed), 32'(rsp_ch.pages_freed));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                busy = 1'b1;
                n_issued++;
                want = apply_command(req_ch.cmd, req_ch.addr, req_ch.range_end);
                if (row_fixed) begin
                    want = row_want;
                end
                awaited_results.push_back(want);
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= (hold_left == 0);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            hold_left = idle_len();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic issue(input logic [pfla_pkg::CMD_W-1:0] c,
                         input logic [pfla_pkg::ADDR_W-1:0] a,
                         input logic [pfla_pkg::ADDR_W-1:0] e, input bit fx,
                         input pfla_pkg::t_result w);
        int gap;
        gap = (idle_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= c;
        req_ch.addr      <= a;
        req_ch.range_end <= e;
        row_fixed        <= fx;
        row_want         <= w;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (n_returned != n_issued);
    endtask

    initial begin : stimulus
        logic [pfla_pkg::CMD_W-1:0]  c;
        logic [pfla_pkg::ADDR_W-1:0] a;
        logic [pfla_pkg::ADDR_W-1:0] e;
        logic [pfla_pkg::ADDR_W-1:0] va;
        int                          idx;
        int                          r;
        int                          n;
        t_setting                    s;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= pfla_pkg::CFG_KERNEL_END;
        cfg_wdata        <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= pfla_pkg::CMD_ALLOC;
        req_ch.addr      <= '0;
        req_ch.range_end <= '0;
        row_fixed        <= 1'b0;
        row_want         <= '0;
        n_issued    = 0;
        n_returned  = 0;
        mismatches  = 0;
        idle_cycles = 0;
        idle_on     = 1'b1;

        directed_rows = '{
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_EMPTY, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8000_0000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd1}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b1,
              '{32'h8000_0000, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{32'h0, pfla_pkg::ST_EMPTY, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8000_0001, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8E00_0000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8DFF_F000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd1}},
            '{pfla_pkg::CMD_FREE,  32'h7FFF_F000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h0000_0000, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}},
            '{pfla_pkg::CMD_RANGE, 32'h8000_1001, 32'h8000_4000, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd2}},
            '{pfla_pkg::CMD_RANGE, 32'h8001_0000, 32'h8001_0FFF, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_RANGE, 32'hFFFF_F001, 32'hFFFF_FFFF, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_RANGE, 32'h8DFF_E000, 32'h8E00_2000, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd2}},
            '{pfla_pkg::CMD_RANGE, 32'h8002_0000, 32'h8001_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{CMD_NONE,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8000_5000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_FREE,  32'h8000_5000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_RANGE, 32'h8010_0000, 32'h8090_0000, 1'b1,
              '{32'h0, pfla_pkg::ST_OK, 17'd2048}},
            '{pfla_pkg::CMD_ALLOC, 32'h0000_0000, 32'h0000_0000, 1'b0,
              '{32'h0, pfla_pkg::ST_OK, 17'd0}},
            '{pfla_pkg::CMD_RANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
              '{32'h0, pfla_pkg::ST_INVALID, 17'd0}}
        };

        settings = '{
            '{32'h8040_0000, 32'h8000_0000, 32'h0800_0000, 32'h400, 32'h8000},
            '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h10, 32'h10000},
            '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000, 0, 32'h100},
            '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFF00, 0},
            '{32'hF000_0000, 32'hF000_0000, 32'h2000_0000, 0, 32'h10000},
            '{32'h0000_0000, 32'h0000_0000, 32'h1000_0000, 0, 32'h10000}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            issue(directed_rows[k].cmd, directed_rows[k].addr, directed_rows[k].range_end,
                  directed_rows[k].fixed, directed_rows[k].want);
        end
        settle();

        foreach (settings[p]) begin
            s = settings[p];
            cfg_we    <= 1'b1;
            cfg_idx   <= pfla_pkg::CFG_KERNEL_END;
            cfg_wdata <= s.kernel_end;
            @(posedge i_clk);
            cfg_idx   <= pfla_pkg::CFG_KERNEL_BASE;
            cfg_wdata <= s.kernel_base;
            @(posedge i_clk);
            cfg_idx   <= pfla_pkg::CFG_PHYS_TOP;
            cfg_wdata <= s.phys_top;
            @(posedge i_clk);
            cfg_we    <= 1'b0;

            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                if (k % 40 == 0) begin
                    idle_on = ($urandom_range(0, 3) != 0);
                end
                r = $urandom_range(0, 99);
                n = $urandom_range(0, 99);
                if (n < 70) begin
                    idx = s.lo + $urandom_range(0, 255);
                end else if (n < 85) begin
                    idx = s.hi - 4 + $urandom_range(0, 8);
                end else begin
                    idx = s.lo - 4 + $urandom_range(0, 8);
                end
                va = s.kernel_base + 32'(idx) * PAGE_SIZE;
                va = (va + PAGE_SIZE - 1) & ~(PAGE_SIZE - 1);
                a = $urandom;
                e = $urandom;
                if (r < 40) begin
                    c = pfla_pkg::CMD_ALLOC;
                end else if (r < 70) begin
                    c = pfla_pkg::CMD_FREE;
                    a = va;
                end else if (r < 78) begin
                    c = pfla_pkg::CMD_FREE;
                    case ($urandom_range(0, 2))
                        0: begin
                        end
                        1: a = va + $urandom_range(1, PAGE_SIZE - 1);
                        default: a = va ^ (32'd1 << $urandom_range(0, 31));
                    endcase
                end else if (r < 93) begin
                    c = pfla_pkg::CMD_RANGE;
                    n = ($urandom_range(0, 49) == 0) ? $urandom_range(64, 1024)
                                                     : $urandom_range(0, 12);
                    a = va - $urandom_range(0, PAGE_SIZE - 1);
                    e = a + n * PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1);
                end else if (r < 97) begin
                    c = pfla_pkg::CMD_RANGE;
                    if ($urandom_range(0, 1) == 1) begin
                        a = 32'hFFFF_F000 + $urandom_range(0, PAGE_SIZE - 1);
                        e = 32'hFFFF_FFFF;
                    end
                end else begin
                    c = CMD_NONE;
                end
                issue(c, a, e, 1'b0, '0);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/pfla_pkg.sv
rtl/pfla_req_if.sv
rtl/pfla_rsp_if.sv
rtl/pfla_ram.sv
rtl/pfla_alu.sv
rtl/pfla_ctrl.sv
rtl/page_free_list_allocator.sv
tb/testbench.sv
